>>> hdl/mf3_pkg.sv
// Shared types, constants and the median network of the 3x3 median filter.
package mf3_pkg;

    localparam int PIX_W = 8;
    localparam int POS_W = 11;
    localparam int CFG_W = 12;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Register indexes on the configuration port.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    // One window column: element 0 is the top row, element 2 the bottom row.
    typedef logic [2:0][PIX_W-1:0] col_t;
    typedef logic [8:0][PIX_W-1:0] pix9_t;

    typedef struct packed {
        pix_t             median;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
    } result_t;

    // Collects nine neighbors from three columns. On the bottom image row the
    // missing row below is replicated from the bottom row of the window.
    function automatic pix9_t gather9(col_t left, col_t center, col_t right,
                                      logic bottom);
        pix9_t v;
        col_t  cols [3];
        cols[0] = left;
        cols[1] = center;
        cols[2] = right;
        for (int k = 0; k < 3; k++)
        begin
            if (bottom)
            begin
                v[3*k]     = cols[k][1];
                v[3*k + 1] = cols[k][2];
                v[3*k + 2] = cols[k][2];
            end
            else
            begin
                v[3*k]     = cols[k][0];
                v[3*k + 1] = cols[k][1];
                v[3*k + 2] = cols[k][2];
            end
        end
        return v;
    endfunction

    function automatic void order2(inout pix_t a, inout pix_t b);
        pix_t t;
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
    endfunction

    // Nineteen compare-exchange median network; the median lands in slot 4.
    function automatic pix_t median9(pix9_t v);
        pix_t p [9];
        for (int i = 0; i < 9; i++)
        begin
            p[i] = v[i];
        end
        order2(p[1], p[2]); order2(p[4], p[5]); order2(p[7], p[8]);
        order2(p[0], p[1]); order2(p[3], p[4]); order2(p[6], p[7]);
        order2(p[1], p[2]); order2(p[4], p[5]); order2(p[7], p[8]);
        order2(p[0], p[3]); order2(p[5], p[8]); order2(p[4], p[7]);
        order2(p[3], p[6]); order2(p[1], p[4]); order2(p[2], p[5]);
        order2(p[4], p[7]); order2(p[2], p[4]); order2(p[4], p[6]);
        order2(p[2], p[4]);
        return p[4];
    endfunction

endpackage

>>> hdl/median_filter_3x3.sv
// Streaming 3x3 median filter with replicated image borders.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | in_valid / in_ready        | pixel
//  output   | out_valid / out_ready      | median, out_row, out_column,
//           |                            | last_of_frame, last_of_item
//  config   | cfg_write                  | cfg_index, cfg_data
//
// One pixel is accepted per clock while in_ready is high. The accepting edge also reads
// the line stores; the window update and the median networks then load the result
// register from the read stage, which holds the pixel while results are pending.
// A pixel causes up to four results and the output port delivers one per beat.
// In the last row each emitting pixel owes two results, so an emitting pixel right
// behind it waits in the read stage; the extra results of a last column are absorbed
// by the following column-zero pixel, which emits nothing. Reset clears counters, window
// and control; line stores are not cleared and need no clearing pass.
module median_filter_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mf3_pkg::pix_t                       pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mf3_pkg::pix_t                       median,
    output logic [mf3_pkg::POS_W-1:0]           out_row,
    output logic [mf3_pkg::POS_W-1:0]           out_column,
    output logic                                last_of_frame,
    output logic                                last_of_item
);
    import mf3_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int SZWW = (WW > CFG_W) ? WW : CFG_W;
    localparam int SZWH = (HW > CFG_W) ? HW : CFG_W;

    // Configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped last indexes
    logic [SZWW-1:0] w_cfg;
    logic [SZWH-1:0] h_cfg;
    logic [CW-1:0]   w_last;
    logic [RW-1:0]   h_last;

    always_comb
    begin
        w_cfg = SZWW'(width_reg);
        h_cfg = SZWH'(height_reg);
        if (w_cfg < SZWW'(2))
            w_last = CW'(1);
        else if (w_cfg > SZWW'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(w_cfg - SZWW'(1));
        if (h_cfg < SZWH'(2))
            h_last = RW'(1);
        else if (h_cfg > SZWH'(MAX_HEIGHT))
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(h_cfg - SZWH'(1));
    end

    // Position counters and the read stage
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] c_cur;
    logic [RW-1:0] r_cur;
    logic          in_beat;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_first_col_reg;
    logic          s1_top_mid_reg;
    logic          s1_emit_reg;
    logic          s1_last_row_reg;
    logic          s1_last_col_reg;
    pix_t          s1_px_reg;
    logic          s1_adv;

    pix_t newer_q;
    pix_t older_q;

    assign c_cur   = (col_reg < w_last) ? col_reg : w_last;
    assign r_cur   = (row_reg < h_last) ? row_reg : h_last;
    assign in_beat = in_valid && in_ready;

    mf3_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_beat),
        .addr    (c_cur),
        .wr_pixel(pixel),
        .newer_q (newer_q),
        .older_q (older_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                if (c_cur == w_last)
                begin
                    col_reg <= '0;
                    row_reg <= (r_cur == h_last) ? '0 : r_cur + RW'(1);
                end
                else
                begin
                    col_reg <= c_cur + CW'(1);
                    row_reg <= r_cur;
                end
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_px_reg        <= pixel;
            s1_col_reg       <= c_cur;
            s1_row_reg       <= r_cur;
            s1_first_col_reg <= (c_cur == '0);
            s1_top_mid_reg   <= (r_cur <= RW'(1));
            s1_emit_reg      <= (r_cur != '0) && (c_cur != '0);
            s1_last_row_reg  <= (r_cur == h_last);
            s1_last_col_reg  <= (c_cur == w_last);
        end
    end

    // Window update and median networks
    col_t    win_reg [3];
    col_t    win_next [3];
    col_t    new_col;
    pix_t    med_a;
    pix_t    med_b;
    pix_t    med_c;
    pix_t    med_d;

    always_comb
    begin
        new_col[0] = s1_top_mid_reg ? newer_q : older_q;
        new_col[1] = newer_q;
        new_col[2] = s1_px_reg;
        if (s1_first_col_reg)
        begin
            win_next[0] = new_col;
            win_next[1] = new_col;
            win_next[2] = new_col;
        end
        else
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = new_col;
        end
        // The extra results of the last column replicate the right edge.
        med_a = median9(gather9(win_next[0], win_next[1], win_next[2], 1'b0));
        med_b = median9(gather9(win_next[0], win_next[1], win_next[2], 1'b1));
        med_c = median9(gather9(win_next[1], win_next[2], win_next[2], 1'b0));
        med_d = median9(gather9(win_next[1], win_next[2], win_next[2], 1'b1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    // Result register: holds all results of one pixel and sends one a beat.
    result_t       s2_entry_reg [4];
    result_t       load_entry [4];
    logic [1:0]    load_last;
    logic          s2_valid_reg;
    logic [1:0]    s2_idx_reg;
    logic [1:0]    s2_last_reg;
    logic          s2_frame_end_reg;
    logic          s2_item_end;
    logic          s2_take;
    logic          s2_free;
    logic          s2_load;
    logic [POS_W-1:0] row_up;
    logic [POS_W-1:0] row_here;
    logic [POS_W-1:0] col_prev;
    logic [POS_W-1:0] col_here;

    assign s2_item_end = (s2_idx_reg == s2_last_reg);
    assign s2_take     = s2_valid_reg && out_ready && s2_item_end;
    assign s2_free     = !s2_valid_reg || s2_take;
    assign s1_adv      = s1_valid_reg && (!s1_emit_reg || s2_free);
    assign s2_load     = s1_adv && s1_emit_reg;
    assign in_ready    = !s1_valid_reg || s1_adv;

    always_comb
    begin
        row_up   = POS_W'(s1_row_reg - RW'(1));
        row_here = POS_W'(s1_row_reg);
        col_prev = POS_W'(s1_col_reg - CW'(1));
        col_here = POS_W'(s1_col_reg);
        load_entry[0] = '{median: med_a, row: row_up, column: col_prev};
        load_entry[1] = '{median: med_b, row: row_here, column: col_prev};
        load_entry[2] = '{median: med_c, row: row_up, column: col_here};
        load_entry[3] = '{median: med_d, row: row_here, column: col_here};
        load_last = 2'd0;
        if (s1_last_row_reg && s1_last_col_reg)
        begin
            load_last = 2'd3;
        end
        else if (s1_last_row_reg)
        begin
            load_last = 2'd1;
        end
        else if (s1_last_col_reg)
        begin
            load_entry[1] = load_entry[2];
            load_last     = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_idx_reg   <= '0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= 1'b1;
            s2_idx_reg   <= '0;
        end
        else if (s2_take)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg && out_ready)
        begin
            s2_idx_reg <= s2_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_entry_reg     <= load_entry;
            s2_last_reg      <= load_last;
            s2_frame_end_reg <= s1_last_row_reg && s1_last_col_reg;
        end
    end

    assign out_valid     = s2_valid_reg;
    assign median        = s2_entry_reg[s2_idx_reg].median;
    assign out_row       = s2_entry_reg[s2_idx_reg].row;
    assign out_column    = s2_entry_reg[s2_idx_reg].column;
    assign last_of_item  = s2_item_end;
    assign last_of_frame = s2_frame_end_reg && s2_item_end;

    // Checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_idx_reg <= s2_last_reg)
        else $error("result index beyond the last result of the pixel");

    a_frame_end_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> last_of_item)
        else $error("frame end flagged on a result that does not end its pixel");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |-> !s2_valid_reg || (out_ready && s2_item_end))
        else $error("result register reloaded while results are pending");

    a_stall_holds_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("read stage lost a stalled pixel");

endmodule

>>> hdl/mf3_line_store.sv
// Two line stores holding the two previous image rows, with registered reads.
module mf3_line_store #(
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  mf3_pkg::pix_t            wr_pixel,
    output mf3_pkg::pix_t            newer_q,
    output mf3_pkg::pix_t            older_q
);
    import mf3_pkg::*;

    localparam int AW = $clog2(DEPTH);

    pix_t newer_mem [DEPTH];
    pix_t older_mem [DEPTH];

    pix_t          newer_q_reg;
    pix_t          older_q_reg;
    logic          shift_reg;
    logic [AW-1:0] shift_addr_reg;

    // The newer row entry is read and replaced by the incoming pixel on the
    // same edge; its old value moves to the older row on the following edge.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            newer_q_reg       <= newer_mem[addr];
            older_q_reg       <= older_mem[addr];
            newer_mem[addr]   <= wr_pixel;
            shift_addr_reg    <= addr;
        end
        if (shift_reg)
        begin
            older_mem[shift_addr_reg] <= newer_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= rd_en;
        end
    end

    assign newer_q = newer_q_reg;
    assign older_q = older_q_reg;

endmodule
